// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the queue's top-level RTL file.
// Each macro takes a label, a clock, a reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequence holds in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// consequence holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/sipq_pkg.sv =====
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants of the sorted-insert priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 8;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REM_EMPTY  = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CHAR_W-1:0] chr;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sipq_cell.sv =====
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted chain: shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_cell (
  input  wire logic               clk,
  input  wire sipq_pkg::cell_ctl_t ctl,
  input  wire logic               occ,          // slot holds a live entry
  input  wire logic               left_place,   // left neighbor takes the new entry or shifts
  input  wire sipq_pkg::entry_t   left_entry,
  input  wire sipq_pkg::entry_t   right_entry,
  output logic                    place,
  output sipq_pkg::entry_t        entry
);

  sipq_pkg::entry_t entry_next;

  // sorted chain: place is a thermometer, true from the insert slot onward
  assign place = !occ || (entry.prio > ctl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    priority if (ctl.rem) begin
      entry_next = right_entry;
    end else if (ctl.ins) begin
      if (left_place) begin
        entry_next = left_entry;
      end else if (place) begin
        entry_next = ctl.new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit
// Bounded priority queue held as a sorted chain of cells, head at cell 0.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | op, new_prio, new_char
//  out     | out_valid/out_ready | out_prio, out_char, status, count,
//          |                     | is_empty, is_full
//
// One item per cycle unless the output stalls: every cell compares against the
// new priority in parallel, so an insert or remove finishes in the cycle it is accepted.
// The result sits in one output register, visible the cycle after accept.
// in_ready is high out of reset whenever that register is empty or being drained.
// Reset clears the count and the output valid; cell contents stay undefined.
// A stalled output holds the result and blocks further input items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_insert_priority_queue_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic [sipq_pkg::PRIO_W-1:0]   new_prio,
  input  wire logic [sipq_pkg::CHAR_W-1:0]   new_char,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sipq_pkg::PRIO_W-1:0]        out_prio,
  output logic [sipq_pkg::CHAR_W-1:0]        out_char,
  output logic [sipq_pkg::STATUS_W-1:0]      status,
  output logic [sipq_pkg::COUNT_W-1:0]       count,
  output logic                               is_empty,
  output logic                               is_full
);

  localparam int N = sipq_pkg::CAPACITY;

  // occupancy count of the chain
  logic [sipq_pkg::CNT_W-1:0] cnt;
  logic [sipq_pkg::CNT_W-1:0] cnt_next;

  logic                 accept;
  logic                 full_now;
  logic                 empty_now;
  logic                 do_ins;
  logic                 do_rem;
  sipq_pkg::cell_ctl_t  ctl;

  logic [N-1:0]         occ;
  logic [N-1:0]         place;
  sipq_pkg::entry_t     cell_entry [N];
  sipq_pkg::entry_t     head;

  // no item is taken while reset is held
  assign in_ready  = !rst && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign full_now  = (cnt == sipq_pkg::CNT_W'(N));
  assign empty_now = (cnt == '0);
  assign do_ins    = accept && (op == sipq_pkg::OP_INSERT) && !full_now;
  assign do_rem    = accept && (op == sipq_pkg::OP_REMOVE) && !empty_now;

  assign ctl.ins            = do_ins;
  assign ctl.rem            = do_rem;
  assign ctl.new_entry.prio = new_prio;
  assign ctl.new_entry.chr  = new_char;

  assign head = cell_entry[0];

  // ---- the chain ----
  for (genvar i = 0; i < N; i++) begin : g_cell
    sipq_pkg::entry_t left_e;
    sipq_pkg::entry_t right_e;
    logic             left_p;

    assign occ[i] = (sipq_pkg::CNT_W'(i) < cnt);

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_p = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_p = place[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    sipq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .left_place  (left_p),
      .left_entry  (left_e),
      .right_entry (right_e),
      .place       (place[i]),
      .entry       (cell_entry[i])
    );
  end

  // ---- count ----
  always_comb begin
    cnt_next = cnt;
    priority if (do_ins) begin
      cnt_next = cnt + 1'b1;
    end else if (do_rem) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_prio <= do_rem ? head.prio : '0;
      out_char <= do_rem ? head.chr  : '0;
      priority if ((op == sipq_pkg::OP_INSERT) && full_now) begin
        status <= sipq_pkg::STATUS_INS_FULL;
      end else if ((op == sipq_pkg::OP_REMOVE) && empty_now) begin
        status <= sipq_pkg::STATUS_REM_EMPTY;
      end else begin
        status <= sipq_pkg::STATUS_DONE;
      end
      count    <= sipq_pkg::COUNT_W'(cnt_next);
      is_empty <= (cnt_next == '0);
      is_full  <= (cnt_next == sipq_pkg::CNT_W'(N));
    end
  end

  // ---- checks ----
  `ASSERT_SAME(a_cnt_bound, clk, rst, 1'b1, cnt <= sipq_pkg::CNT_W'(N))
  `ASSERT_NEXT(a_ins_grows, clk, rst, do_ins, cnt == $past(cnt) + 1'b1)
  `ASSERT_NEXT(a_rem_head, clk, rst, do_rem,
               out_prio == $past(head.prio) && out_char == $past(head.chr))
  `ASSERT_SAME(a_full_status, clk, rst,
               out_valid && status == sipq_pkg::STATUS_INS_FULL, is_full)

endmodule

`default_nettype wire

// ===== test/sorted_insert_priority_queue_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit_test
// Self-checking bench for the sorted-insert priority queue. A local software
// queue predicts each result. Directed items cover the empty, full and
// tied-priority cases. Random traffic runs under three sender/receiver
// stall profiles.
// ----------------------------------------------------------------------------

module sorted_insert_priority_queue_unit_test;

  // Cycles with no handshake on either channel before the run is abandoned.
  // Slowest legal run stalls the receiver 68% of cycles, so reaching this
  // limit is vanishingly rare.
  localparam int STALL_LIMIT   = 1000;
  // Output register holds one result, so this settle wait covers its latency.
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 510;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic [sipq_pkg::PRIO_W-1:0]   prio;
    logic [sipq_pkg::CHAR_W-1:0]   chr;
    logic [sipq_pkg::STATUS_W-1:0] status;
    logic [sipq_pkg::COUNT_W-1:0]  count;
    logic                          is_empty;
    logic                          is_full;
  } queue_result_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic                          op        = sipq_pkg::OP_INSERT;
  logic [sipq_pkg::PRIO_W-1:0]   new_prio  = '0;
  logic [sipq_pkg::CHAR_W-1:0]   new_char  = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [sipq_pkg::PRIO_W-1:0]   out_prio;
  logic [sipq_pkg::CHAR_W-1:0]   out_char;
  logic [sipq_pkg::STATUS_W-1:0] status;
  logic [sipq_pkg::COUNT_W-1:0]  count;
  logic                          is_empty;
  logic                          is_full;

  // Predicted queue contents, head at index 0, and results not yet seen.
  sipq_pkg::entry_t held_entries[$];
  queue_result_t    pending_results[$];

  int error_count  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;

  sorted_insert_priority_queue_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .new_prio  (new_prio),
    .new_char  (new_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_prio  (out_prio),
    .out_char  (out_char),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Queue predictor: applies one operation to held_entries, returns the
  // result the block should produce for it.
  // --------------------------------------------------------------------------
  function automatic queue_result_t predict_queue_op(
      logic op_code, logic [sipq_pkg::PRIO_W-1:0] prio,
      logic [sipq_pkg::CHAR_W-1:0] chr);
    queue_result_t    r;
    sipq_pkg::entry_t e;
    int               pos;
    r        = '0;
    r.status = sipq_pkg::STATUS_DONE;
    if (op_code == sipq_pkg::OP_INSERT) begin
      if (held_entries.size() >= sipq_pkg::CAPACITY) begin
        r.status = sipq_pkg::STATUS_INS_FULL;
      end else begin
        // walk back past every entry with a larger priority number;
        // equal priorities stay ahead, which keeps ties in arrival order
        pos = held_entries.size();
        while (pos > 0 && held_entries[pos-1].prio > prio) pos--;
        e.prio = prio;
        e.chr  = chr;
        held_entries.insert(pos, e);
      end
    end else begin
      if (held_entries.size() == 0) begin
        r.status = sipq_pkg::STATUS_REM_EMPTY;
      end else begin
        e      = held_entries.pop_front();
        r.prio = e.prio;
        r.chr  = e.chr;
      end
    end
    r.count    = sipq_pkg::COUNT_W'(held_entries.size());
    r.is_empty = (held_entries.size() == 0);
    r.is_full  = (held_entries.size() == sipq_pkg::CAPACITY);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Sender: idle cycles drawn one at a time at the current rate, then hold the
  // item until in_ready is seen at a rising edge. Valid stays high between
  // back-to-back items, so it is never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_queue_op(logic op_code, logic [sipq_pkg::PRIO_W-1:0] prio,
                               logic [sipq_pkg::CHAR_W-1:0] chr);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_code;
    new_prio <= prio;
    new_char <= chr;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_queue_op(op_code, prio, chr));
  endtask

  // Stop sending until every predicted result has come out.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Remove right after reset: rejected, queue stays empty.
  task automatic test_remove_when_empty();
    send_queue_op(sipq_pkg::OP_REMOVE, 8'hFF, 8'hFF);
  endtask

  // Fill all 16 cells with extreme and tied priorities, then one more insert
  // that must bounce with the full status.
  task automatic test_fill_and_overflow();
    logic [sipq_pkg::PRIO_W-1:0] prio_seq[16];
    prio_seq = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd7, 8'd0, 8'd255, 8'd128,
                 8'd7, 8'd1, 8'd254, 8'd0, 8'd7, 8'd128, 8'd255, 8'd0};
    for (int i = 0; i < sipq_pkg::CAPACITY; i++)
      send_queue_op(sipq_pkg::OP_INSERT, prio_seq[i], sipq_pkg::CHAR_W'(i * 17));
    send_queue_op(sipq_pkg::OP_INSERT, 8'd0, 8'hAA);
  endtask

  // Pull the head several times: the four priority-0 entries come out first
  // in arrival order, then the single priority 1.
  task automatic test_ordered_drain();
    repeat (5) send_queue_op(sipq_pkg::OP_REMOVE, 8'h00, 8'h00);
    hold_until_drained();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Every 40 items a new insert bias and priority spread are
  // picked so the fill level swings between empty and full; the narrow spread
  // produces many ties to exercise first-in, first-out order.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
    int                          ins_pct;
    int                          prio_mode;
    logic                        op_code;
    logic [sipq_pkg::PRIO_W-1:0] prio;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    ins_pct      = 50;
    prio_mode    = 1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       ins_pct = 15;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
        prio_mode = $urandom_range(2);
      end
      op_code = ($urandom_range(99) < ins_pct) ? sipq_pkg::OP_INSERT
                                                : sipq_pkg::OP_REMOVE;
      case (prio_mode)
        0:       prio = sipq_pkg::PRIO_W'($urandom_range(3));
        1:       prio = sipq_pkg::PRIO_W'($urandom_range(255));
        default: prio = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      send_queue_op(op_code, prio, sipq_pkg::CHAR_W'($urandom_range(255)));
    end
  endtask

  // Receiver: stall at the current rate, decided fresh each cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with no prediction waiting");
      end else begin
        automatic queue_result_t want = pending_results.pop_front();
        check_field("out_prio", out_prio, want.prio);
        check_field("out_char", out_char, want.chr);
        check_field("status",   status,   want.status);
        check_field("count",    count,    want.count);
        check_field("is_empty", is_empty, want.is_empty);
        check_field("is_full",  is_full,  want.is_full);
      end
    end
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_remove_when_empty();
    test_fill_and_overflow();
    test_ordered_drain();

    // sender rarely idles, receiver stalls most cycles
    test_random_traffic(RANDOM_ITEMS, 6, 68);
    hold_until_drained();
    // sender idles most cycles, receiver rarely stalls
    test_random_traffic(RANDOM_ITEMS, 68, 6);
    hold_until_drained();
    // full rate on both sides
    test_random_traffic(RANDOM_ITEMS, 0, 0);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
